// ----- rtl/mjfx_pkg.sv -----
`timescale 1ns / 1ps

package mjfx_pkg;

  // Capture buffer size; a marker pair counts only if its FF is below BUFFER_BYTES - 4
  localparam int unsigned BUFFER_BYTES = 20480;

  localparam int unsigned POS_W = 15;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  // Limit on the position of the second marker byte (pair position + 1)
  localparam logic [POS_W:0] PAIR_END = (POS_W+1)'(BUFFER_BYTES - 3);

  // JPEG marker bytes
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;

  // AVI bookkeeping: idx1 offsets start at 4, RIFF size base is 170
  localparam logic [31:0] IDX_START  = 32'd4;
  localparam logic [31:0] RIFF_START = 32'd170;
  localparam logic [31:0] IDX_STEP   = 32'd8;
  localparam logic [31:0] RIFF_STEP  = 32'd24;

  typedef enum logic [1:0] {
    PH_SEEK_START = 2'd0,
    PH_SEEK_END   = 2'd1,
    PH_DONE       = 2'd2
  } mjfx_phase_t;

  // Frame found by the scanner, handed to the tally stage
  typedef struct packed {
    logic             fire;
    logic [POS_W-1:0] frame_start;
    logic [POS_W-1:0] chunk_length;
  } mjfx_evt_t;

endpackage

// ----- rtl/mjfx_scan.sv -----
`timescale 1ns / 1ps

module mjfx_scan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_buffer_start,
  input  logic                     sink_free,
  output mjfx_pkg::mjfx_evt_t      evt
);
  import mjfx_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic             s1_start_r;
  logic             advance;
  logic             load;

  logic [7:0]       prev_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  mjfx_phase_t      phase_r, phase_nxt;
  logic [POS_W-1:0] begin_r, begin_nxt;

  logic [POS_W-1:0] cur;
  mjfx_phase_t      phase_eff;
  logic             pair_ok, soi_hit, eoi_hit;

  // Input register handshake
  assign advance  = s1_valid_r && sink_free;
  assign in_stall = s1_valid_r && !sink_free;
  assign load     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_buffer_start;
    end
  end

  // Marker search on the registered byte
  always_comb begin
    cur       = s1_start_r ? '0 : pos_r;
    phase_eff = s1_start_r ? PH_SEEK_START : phase_r;
    pair_ok   = (cur != '0) && ({1'b0, cur} < PAIR_END) && (prev_r == MARK_PREFIX);
    soi_hit   = pair_ok && (phase_eff == PH_SEEK_START) && (s1_byte_r == MARK_SOI);
    eoi_hit   = pair_ok && (phase_eff == PH_SEEK_END) && (s1_byte_r == MARK_EOI);

    phase_nxt = phase_eff;
    begin_nxt = begin_r;
    if (soi_hit) begin
      phase_nxt = PH_SEEK_END;
      begin_nxt = cur - POS_W'(1);
    end else if (eoi_hit) begin
      phase_nxt = PH_DONE;
    end
    pos_nxt = (cur == POS_MAX) ? POS_MAX : cur + POS_W'(1);

    evt.fire         = advance && eoi_hit;
    evt.frame_start  = begin_r;
    evt.chunk_length = cur + POS_W'(1) - begin_r;
  end

  // Search state, updated once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      pos_r   <= '0;
      phase_r <= PH_SEEK_START;
      begin_r <= '0;
    end else if (advance) begin
      prev_r  <= s1_byte_r;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      begin_r <= begin_nxt;
    end
  end

endmodule

// ----- rtl/mjfx_tally.sv -----
`timescale 1ns / 1ps

module mjfx_tally (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mjfx_pkg::mjfx_evt_t      evt,
  output logic                     sink_free,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [14:0]              out_frame_start,
  output logic [14:0]              out_chunk_length,
  output logic                     out_pad_needed,
  output logic [31:0]              out_index_offset,
  output logic [31:0]              out_frame_total,
  output logic [31:0]              out_movi_size,
  output logic [31:0]              out_riff_size
);
  import mjfx_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [31:0] riff_r, riff_nxt;
  logic        pad;
  logic [31:0] padded;

  logic [POS_W-1:0] start_r, len_r;
  logic             pad_r;
  logic [31:0]      offset_r, total_r, movi_r, riffo_r;

  assign sink_free = !valid_r || !out_stall;

  // Running totals; idx1 offset after a frame equals the movi size
  always_comb begin
    pad        = evt.chunk_length[0];
    padded     = 32'(evt.chunk_length) + 32'(pad);
    frames_nxt = frames_r + 32'd1;
    idx_nxt    = idx_r + IDX_STEP + padded;
    riff_nxt   = riff_r + RIFF_STEP + padded;

    valid_nxt = valid_r;
    if (evt.fire) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      frames_r <= '0;
      idx_r    <= IDX_START;
      riff_r   <= RIFF_START;
    end else begin
      valid_r <= valid_nxt;
      if (evt.fire) begin
        frames_r <= frames_nxt;
        idx_r    <= idx_nxt;
        riff_r   <= riff_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (evt.fire) begin
      start_r  <= evt.frame_start;
      len_r    <= evt.chunk_length;
      pad_r    <= pad;
      offset_r <= idx_r;
      total_r  <= frames_nxt;
      movi_r   <= idx_nxt;
      riffo_r  <= riff_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_frame_start  = start_r;
  assign out_chunk_length = len_r;
  assign out_pad_needed   = pad_r;
  assign out_index_offset = offset_r;
  assign out_frame_total  = total_r;
  assign out_movi_size    = movi_r;
  assign out_riff_size    = riffo_r;

endmodule

// ----- rtl/mjpeg_frame_extract_avi_index.sv -----
`timescale 1ns / 1ps
// A byte waits in the input register; the frame it ends is held in the result register.
// Throughput: one byte per cycle; while a result waits for its sink the input register
// still takes one more byte, then the input stalls until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, restarts the marker search
// at buffer position 0, and sets frame count 0, idx1 offset 4 and RIFF base 170.
module mjpeg_frame_extract_avi_index (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_frame_start,
  output logic [14:0] out_chunk_length,
  output logic        out_pad_needed,
  output logic [31:0] out_index_offset,
  output logic [31:0] out_frame_total,
  output logic [31:0] out_movi_size,
  output logic [31:0] out_riff_size
);
  import mjfx_pkg::*;

  mjfx_evt_t evt;
  logic      sink_free;

  // Input register and marker search
  mjfx_scan u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_buffer_start (in_buffer_start),
    .sink_free       (sink_free),
    .evt             (evt)
  );

  // AVI totals and result register
  mjfx_tally u_tally (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt              (evt),
    .sink_free        (sink_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_start  (out_frame_start),
    .out_chunk_length (out_chunk_length),
    .out_pad_needed   (out_pad_needed),
    .out_index_offset (out_index_offset),
    .out_frame_total  (out_frame_total),
    .out_movi_size    (out_movi_size),
    .out_riff_size    (out_riff_size)
  );

endmodule

// ----- rtl/mjfx_checker.sv -----
`timescale 1ns / 1ps

module mjfx_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_stall,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [14:0] out_chunk_length,
  input  logic        out_pad_needed,
  input  logic [31:0] out_index_offset,
  input  logic [31:0] out_frame_total,
  input  logic [31:0] out_movi_size,
  input  logic [31:0] out_riff_size
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Input back-pressure only when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  // Pad flag follows chunk length parity
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pad_needed == out_chunk_length[0])
    else $error("pad flag wrong");

  // movi size is this chunk's offset plus its header and padded data
  a_movi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_movi_size ==
      out_index_offset + 32'd8 + {17'd0, out_chunk_length} + {31'd0, out_pad_needed})
    else $error("movi size inconsistent");

  // RIFF size tracks movi size by a fixed base plus 16 per frame
  a_riff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_riff_size - out_movi_size == 32'd166 + (out_frame_total << 4))
    else $error("RIFF size inconsistent");

endmodule

bind mjpeg_frame_extract_avi_index mjfx_checker u_mjfx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_chunk_length (out_chunk_length),
  .out_pad_needed   (out_pad_needed),
  .out_index_offset (out_index_offset),
  .out_frame_total  (out_frame_total),
  .out_movi_size    (out_movi_size),
  .out_riff_size    (out_riff_size)
);

// ----- dv/tb_mjpeg_frame_extract_avi_index.sv -----
`timescale 1ns / 1ps

module tb_mjpeg_frame_extract_avi_index;
  import mjfx_pkg::*;

  // One capture byte waiting to be sent, with the idling mix of its phase
  typedef struct {
    logic [7:0] data;
    logic       start;
    int         idle_pct;
    int         stall_pct;
    bit         drain_first;
  } capture_byte_t;

  // One frame record as the block should emit it
  typedef struct {
    logic [14:0] frame_start;
    logic [14:0] chunk_length;
    logic        pad_needed;
    logic [31:0] index_offset;
    logic [31:0] frame_total;
    logic [31:0] movi_size;
    logic [31:0] riff_size;
  } frame_record_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_buffer_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] out_frame_start;
  logic [14:0] out_chunk_length;
  logic        out_pad_needed;
  logic [31:0] out_index_offset;
  logic [31:0] out_frame_total;
  logic [31:0] out_movi_size;
  logic [31:0] out_riff_size;

  capture_byte_t capture_bytes[$];
  frame_record_t expected_frames[$];
  int            errors = 0;
  int            frames_waiting = 0;
  int            stall_pct = 0;
  bit            bytes_all_sent = 1'b0;

  // Stimulus generation settings for the current phase
  int gen_idle = 0;
  int gen_stall = 0;
  bit gen_drain = 1'b0;
  int gen_count = 0;

  // Shadow of the scanner and tally state
  logic [7:0]  scan_prev = 8'h00;
  logic [14:0] scan_pos = '0;
  mjfx_phase_t scan_phase = PH_SEEK_START;
  logic [14:0] scan_begin = '0;
  logic [31:0] tally_frames = '0;
  logic [31:0] tally_padded = '0;
  logic [31:0] tally_next_idx = IDX_START;

  mjpeg_frame_extract_avi_index dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_buffer_start  (in_buffer_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_start  (out_frame_start),
    .out_chunk_length (out_chunk_length),
    .out_pad_needed   (out_pad_needed),
    .out_index_offset (out_index_offset),
    .out_frame_total  (out_frame_total),
    .out_movi_size    (out_movi_size),
    .out_riff_size    (out_riff_size)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame scan for one accepted byte; queues the frame record it completes
  task automatic scan_byte(input logic [7:0] data, input logic start);
    logic [14:0]   cur;
    logic [14:0]   pair;
    logic [14:0]   len;
    logic [31:0]   padded;
    frame_record_t rec;
    if (start) begin
      cur = '0;
      scan_phase = PH_SEEK_START;
    end else begin
      cur = scan_pos;
    end
    if (cur >= 15'd1) begin
      pair = cur - 15'd1;
      if (32'(pair) < BUFFER_BYTES - 4 && scan_prev == MARK_PREFIX) begin
        if (scan_phase == PH_SEEK_START && data == MARK_SOI) begin
          scan_phase = PH_SEEK_END;
          scan_begin = pair;
        end else if (scan_phase == PH_SEEK_END && data == MARK_EOI) begin
          len = pair + 15'd2 - scan_begin;
          padded = 32'(len) + 32'(len[0]);
          rec.index_offset = tally_next_idx;
          tally_frames = tally_frames + 32'd1;
          tally_padded = tally_padded + padded;
          tally_next_idx = tally_next_idx + IDX_STEP + padded;
          scan_phase = PH_DONE;
          rec.frame_start = scan_begin;
          rec.chunk_length = len;
          rec.pad_needed = len[0];
          rec.frame_total = tally_frames;
          rec.movi_size = tally_padded + IDX_START + IDX_STEP * tally_frames;
          rec.riff_size = RIFF_START + tally_padded + RIFF_STEP * tally_frames;
          expected_frames.push_back(rec);
        end
      end
    end
    scan_prev = data;
    scan_pos = (cur < POS_MAX) ? cur + 15'd1 : POS_MAX;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic start);
    capture_byte_t item;
    item.data = data;
    item.start = start;
    item.idle_pct = gen_idle;
    item.stall_pct = gen_stall;
    item.drain_first = gen_drain;
    gen_drain = 1'b0;
    capture_bytes.push_back(item);
    gen_count++;
  endtask

  // Short buffer: marker-heavy noise, usually with a start and end marker laid in
  task automatic push_random_buffer();
    int         len;
    int         p;
    int         q;
    int         r;
    bit         first_start;
    logic [7:0] bytes_q[$];
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 32);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 15);
      if (r < 2) bytes_q.push_back(MARK_PREFIX);
      else if (r == 2) bytes_q.push_back(MARK_SOI);
      else if (r == 3) bytes_q.push_back(MARK_EOI);
      else bytes_q.push_back(8'($urandom_range(0, 255)));
    end
    if (len >= 4 && $urandom_range(0, 9) < 8) begin
      p = $urandom_range(0, len - 4);
      bytes_q[p] = MARK_PREFIX;
      bytes_q[p+1] = MARK_SOI;
      if ($urandom_range(0, 19) < 17) begin
        q = $urandom_range(p + 2, len - 2);
        bytes_q[q] = MARK_PREFIX;
        bytes_q[q+1] = MARK_EOI;
      end
    end
    // now and then the buffer flag is missing or turns up mid-buffer
    first_start = ($urandom_range(0, 9) != 0);
    for (int i = 0; i < len; i++) begin
      push_byte(bytes_q[i], (i == 0) ? first_start : ($urandom_range(0, 49) == 0));
    end
  endtask

  // Driver: presents the next capture byte, holding it while stalled
  always @(posedge clk) begin : drive_bytes
    capture_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || !in_stall) begin
        if (capture_bytes.size() != 0 &&
            (!capture_bytes[0].drain_first || (!in_valid && frames_waiting == 0)) &&
            $urandom_range(0, 99) >= capture_bytes[0].idle_pct) begin
          nxt = capture_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= nxt.data;
          in_buffer_start <= nxt.start;
          stall_pct <= nxt.stall_pct;
        end else begin
          in_valid <= 1'b0;
        end
      end
      bytes_all_sent <= (capture_bytes.size() == 0);
    end
  end

  // Monitor: checks each frame record, then scans the byte taken this edge
  always @(posedge clk) begin : watch_frames
    frame_record_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected frame record: expected none, actual start %0d length %0d",
                   $time, out_frame_start, out_chunk_length);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_start", 32'(want.frame_start), 32'(out_frame_start));
          check_field("chunk_length", 32'(want.chunk_length), 32'(out_chunk_length));
          check_field("pad_needed", 32'(want.pad_needed), 32'(out_pad_needed));
          check_field("index_offset", want.index_offset, out_index_offset);
          check_field("frame_total", want.frame_total, out_frame_total);
          check_field("movi_size", want.movi_size, out_movi_size);
          check_field("riff_size", want.riff_size, out_riff_size);
        end
      end
      if (in_valid && !in_stall) scan_byte(in_data_byte, in_buffer_start);
      frames_waiting <= expected_frames.size();
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Hard limit on run length
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : run
    int phase_idle[4];
    int phase_stall[4];
    int first;
    phase_idle = '{0, 79, 0, 13};
    phase_stall = '{0, 0, 79, 13};

    // bytes straight after reset form a buffer of their own
    push_byte(8'hFF, 1'b0);
    push_byte(MARK_SOI, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(MARK_EOI, 1'b0);
    // one frame per buffer: this pair is ignored
    push_byte(8'hFF, 1'b0);
    push_byte(MARK_SOI, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(MARK_EOI, 1'b0);
    // first byte of a buffer never closes a pair; repeated prefix; second start ignored
    push_byte(MARK_SOI, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(MARK_SOI, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(MARK_SOI, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(MARK_EOI, 1'b0);
    // end marker before any start marker
    push_byte(8'hFF, 1'b1);
    push_byte(MARK_EOI, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(MARK_SOI, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(MARK_EOI, 1'b0);
    // new buffer arrives mid-frame
    push_byte(8'hFF, 1'b1);
    push_byte(MARK_SOI, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(MARK_EOI, 1'b0);

    // random buffers under each idling mix; each phase waits for the block to drain
    for (int ph = 0; ph < 4; ph++) begin
      gen_idle = phase_idle[ph];
      gen_stall = phase_stall[ph];
      gen_drain = 1'b1;
      first = gen_count;
      while (gen_count - first < 205) push_random_buffer();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (!(bytes_all_sent && !in_valid && frames_waiting == 0));
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
